[src/lzbd_pkg.sv]
// ----------------------------------------------------------------------------
// lzbd_pkg
// types, constants and code tables of the bit-flag lz decompressor
// ----------------------------------------------------------------------------
package lzbd_pkg;

  localparam logic [8:0]  ESC_LEN     = 9'd25;
  localparam logic [4:0]  ESC_VALUE   = 5'd25;
  localparam logic [7:0]  SKIP_CODE   = 8'hFE;
  localparam logic [7:0]  END_CODE    = 8'hFF;
  localparam logic [13:0] WRITTEN_CAP = 14'd16383;
  localparam int unsigned LEN_TREE_SIZE = 47;
  localparam int unsigned OFF_TREE_SIZE = 63;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LEN_TREE,
    PH_OFF_TREE,
    PH_LITERAL,
    PH_ESCAPE,
    PH_OFF_LOW
  } phase_e;

  typedef enum logic [1:0] {
    RL_NONE,
    RL_LOW,
    RL_HIGH
  } reload_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FLUSH,
    ST_END,
    ST_WALK
  } state_e;

  // relative child links, both zero on a leaf
  typedef struct packed {
    logic [4:0] l;
    logic [4:0] r;
    logic [4:0] v;
  } tnode_t;

  typedef struct packed {
    logic [5:0] node;
    logic       leaf;
    logic [4:0] value;
  } walk_res_t;

  localparam tnode_t LEN_TREE [0:46] = '{
    '{5'd4,5'd1,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd2}, '{5'd0,5'd0,5'd3},
    '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd4}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd5}, '{5'd0,5'd0,5'd6}, '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd7}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd8}, '{5'd0,5'd0,5'd9},
    '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd10}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd11}, '{5'd0,5'd0,5'd12}, '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd25}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd13}, '{5'd0,5'd0,5'd14},
    '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd15}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd16}, '{5'd0,5'd0,5'd17}, '{5'd1,5'd6,5'd0}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd18}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd19}, '{5'd0,5'd0,5'd20},
    '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd21}, '{5'd0,5'd0,5'd22},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd23}, '{5'd0,5'd0,5'd24}
  };

  localparam tnode_t OFF_TREE [0:62] = '{
    '{5'd2,5'd1,5'd0}, '{5'd0,5'd0,5'd0}, '{5'd1,5'd12,5'd0}, '{5'd1,5'd4,5'd0},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd1}, '{5'd0,5'd0,5'd2}, '{5'd1,5'd4,5'd0},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd3}, '{5'd0,5'd0,5'd4}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd5}, '{5'd0,5'd0,5'd6}, '{5'd1,5'd18,5'd0}, '{5'd1,5'd8,5'd0},
    '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd7}, '{5'd0,5'd0,5'd8},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd9}, '{5'd0,5'd0,5'd10}, '{5'd1,5'd4,5'd0},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd11}, '{5'd0,5'd0,5'd12}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd13}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd14}, '{5'd0,5'd0,5'd15},
    '{5'd1,5'd16,5'd0}, '{5'd1,5'd8,5'd0}, '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0},
    '{5'd0,5'd0,5'd16}, '{5'd0,5'd0,5'd17}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd18},
    '{5'd0,5'd0,5'd19}, '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd20},
    '{5'd0,5'd0,5'd21}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd22}, '{5'd0,5'd0,5'd23},
    '{5'd1,5'd8,5'd0}, '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd24},
    '{5'd0,5'd0,5'd25}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd26}, '{5'd0,5'd0,5'd27},
    '{5'd1,5'd4,5'd0}, '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd28}, '{5'd0,5'd0,5'd29},
    '{5'd1,5'd2,5'd0}, '{5'd0,5'd0,5'd30}, '{5'd0,5'd0,5'd31}
  };

endpackage

[src/lzbd_if.sv]
// ----------------------------------------------------------------------------
// lzbd channels
// valid/ready channels for compressed bytes in and decoded bytes out
// ----------------------------------------------------------------------------
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        stream_end;
  modport source (output valid, output out_bytes, output byte_count,
                  output last_of_run, output stream_end, input ready);
  modport sink   (input valid, input out_bytes, input byte_count,
                  input last_of_run, input stream_end, output ready);
endinterface

[src/lzbd_code_walker.sv]
// ----------------------------------------------------------------------------
// lzbd_code_walker
// one step down the length or offset prefix code tree per flag bit
// ----------------------------------------------------------------------------
module lzbd_code_walker (
  input  logic              is_len_i,
  input  logic [5:0]        node_i,
  input  logic              bit_i,
  output lzbd_pkg::walk_res_t res_o
);
  import lzbd_pkg::*;

  logic [5:0] size;
  logic [5:0] n0;
  logic [6:0] n1;
  logic [5:0] n2;
  tnode_t     cur;
  tnode_t     nxt;

  always_comb begin
    size = is_len_i ? 6'(LEN_TREE_SIZE) : 6'(OFF_TREE_SIZE);
    n0   = (node_i < size) ? node_i : 6'd0;
    cur  = is_len_i ? LEN_TREE[n0] : OFF_TREE[n0];
    n1   = {1'b0, n0} + {2'b00, (bit_i ? cur.r : cur.l)};
    n2   = (n1 >= {1'b0, size}) ? 6'd0 : n1[5:0];
    nxt  = is_len_i ? LEN_TREE[n2] : OFF_TREE[n2];
    res_o.node  = n2;
    res_o.leaf  = (nxt.l == 5'd0) && (nxt.r == 5'd0);
    res_o.value = nxt.v;
  end

endmodule

[src/lzbd_history.sv]
// ----------------------------------------------------------------------------
// lzbd_history
// history memory, one write and one registered read port
// ----------------------------------------------------------------------------
module lzbd_history #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lz_bitflag_decompressor.sv]
// ----------------------------------------------------------------------------
// lz_bitflag_decompressor
// lz77 decoder with 16-bit flag words and prefix-coded length and offset
// ----------------------------------------------------------------------------
// compressed bytes enter on in_ch one item at a time; decoded bytes leave on
// out_ch packed BYTES_PER_RESULT to an item, first byte in bits 7:0.
// in_ch is ready only while the sequencer idles, so one item is worked on
// at a time:
//   flag word byte: taken while idle; the high byte then starts the bit walk
//   literal: take, write, flush the partial result, then the walk
//   back reference: take the offset byte, then per copied byte a history
//     read and then a write, and a flush for a partial last result; copies
//     run up to 278 bytes, followed by the bit walk
//   end code: take, report, plus the output handshake
//   bit walk: one flag or prefix code bit per cycle while bits last, then
//     a step to hand back to idle
// the flag bit walk uses one shared tree stepping unit, one bit per cycle.
// out_ch is driven from an output register; when the receiver stalls the
// copy holds in place until the register frees up, nothing is dropped.
// reset clears the sequencer, the flag and parse state and the counters;
// the history memory is not cleared, since bytes never written are never used.
// after the end code every further item is taken and dropped.
// ----------------------------------------------------------------------------
module lz_bitflag_decompressor #(
  parameter int unsigned HISTORY_DEPTH    = 8192,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzbd_in_if.sink    in_ch,
  lzbd_out_if.source out_ch
);
  import lzbd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  // control state
  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  reload_e     reload_q, reload_d;
  logic [15:0] flag_word_q, flag_word_d;
  logic [4:0]  used_q, used_d;
  logic [5:0]  node_q, node_d;
  logic [8:0]  pend_q, pend_d;
  logic [4:0]  oh_q, oh_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [13:0] written_q, written_d;
  logic        finished_q, finished_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [12:0] off_q, off_d;
  logic        lit_q, lit_d;
  logic [7:0]  lit_byte_q, lit_byte_d;
  logic        src_ok_q, src_ok_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  acc_cnt_q, acc_cnt_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_bytes_q, out_bytes_d;
  logic [3:0]  out_cnt_q, out_cnt_d;
  logic        out_last_q, out_last_d;
  logic        out_end_q, out_end_d;

  // history port
  logic          hist_we;
  logic          hist_re;
  logic [AW-1:0] hist_raddr;
  logic [7:0]    hist_wdata;
  logic [7:0]    hist_rdata;

  // shared tree stepping unit
  logic      cur_bit;
  walk_res_t walk;

  logic          out_free;
  logic          acc_full;
  logic [7:0]    put_byte;
  logic [AW:0]   src_wide;
  logic [AW-1:0] off_ext;
  logic [AW-1:0] wp_inc;

  lzbd_code_walker u_walker (
    .is_len_i (phase_q == PH_LEN_TREE),
    .node_i   (node_q),
    .bit_i    (cur_bit),
    .res_o    (walk)
  );

  lzbd_history #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (wp_q),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  assign cur_bit  = flag_word_q[used_q[3:0]];
  assign out_free = !out_valid_q || out_ch.ready;
  assign acc_full = ({1'b0, acc_cnt_q} + 5'd1) == 5'(BYTES_PER_RESULT);
  assign put_byte = lit_q ? lit_byte_q : (src_ok_q ? hist_rdata : 8'd0);
  assign off_ext  = AW'(off_q);
  // offsets are 13 bits and the history must hold at least 8192 bytes (the block
  // does not check HISTORY_DEPTH), so that an offset never reaches past the whole history
  assign src_wide = (wp_q >= off_ext) ? {1'b0, wp_q} - {1'b0, off_ext}
                  : {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - {1'b0, off_ext};
  assign hist_raddr = src_wide[AW-1:0];
  assign hist_wdata = put_byte;
  assign wp_inc = ({1'b0, wp_q} + 1'b1 >= (AW+1)'(HISTORY_DEPTH)) ? '0 : wp_q + 1'b1;

  assign in_ch.ready        = (state_q == ST_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.out_bytes   = out_bytes_q;
  assign out_ch.byte_count  = out_cnt_q;
  assign out_ch.last_of_run = out_last_q;
  assign out_ch.stream_end  = out_end_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    reload_d    = reload_q;
    flag_word_d = flag_word_q;
    used_d      = used_q;
    node_d      = node_q;
    pend_d      = pend_q;
    oh_d        = oh_q;
    wp_d        = wp_q;
    written_d   = written_q;
    finished_d  = finished_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    lit_d       = lit_q;
    lit_byte_d  = lit_byte_q;
    src_ok_d    = src_ok_q;
    acc_d       = acc_q;
    acc_cnt_d   = acc_cnt_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_bytes_d = out_bytes_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    hist_we     = 1'b0;
    hist_re     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_ch.valid && !finished_q) begin
          if (reload_q == RL_LOW) begin
            flag_word_d = {8'd0, in_ch.in_byte};
            reload_d    = RL_HIGH;
          end else if (reload_q == RL_HIGH) begin
            flag_word_d = {in_ch.in_byte, flag_word_q[7:0]};
            reload_d    = RL_NONE;
            state_d     = ST_WALK;
          end else begin
            case (phase_q)
              PH_LITERAL: begin
                lit_d      = 1'b1;
                lit_byte_d = in_ch.in_byte;
                cnt_d      = 9'd1;
                phase_d    = PH_FLAG;
                state_d    = ST_COPY_WR;
              end
              PH_ESCAPE: begin
                if (in_ch.in_byte == SKIP_CODE) begin
                  phase_d = PH_FLAG;
                  state_d = ST_WALK;
                end else if (in_ch.in_byte == END_CODE) begin
                  phase_d = PH_FLAG;
                  state_d = ST_END;
                end else begin
                  pend_d  = {1'b0, in_ch.in_byte} + ESC_LEN;
                  node_d  = 6'd0;
                  phase_d = PH_OFF_TREE;
                  state_d = ST_WALK;
                end
              end
              PH_OFF_LOW: begin
                off_d   = {oh_q, in_ch.in_byte};
                cnt_d   = pend_q;
                lit_d   = 1'b0;
                phase_d = PH_FLAG;
                state_d = (pend_q == 9'd0) ? ST_WALK : ST_COPY_RD;
              end
              default: begin
                phase_d = PH_FLAG;
                state_d = ST_WALK;
              end
            endcase
          end
        end
      end

      // issue the history read and decide whether the source is real data
      ST_COPY_RD: begin
        hist_re  = 1'b1;
        src_ok_d = (off_q != 13'd0) && ({1'b0, off_q} <= written_q);
        state_d  = ST_COPY_WR;
      end

      // append one byte; a full result waits for the output register
      ST_COPY_WR: begin
        if (!acc_full || out_free) begin
          hist_we   = 1'b1;
          wp_d      = wp_inc;
          written_d = (written_q < WRITTEN_CAP) ? written_q + 14'd1 : written_q;
          cnt_d     = cnt_q - 9'd1;
          if (acc_full) begin
            out_valid_d = 1'b1;
            out_bytes_d = acc_q | ({56'd0, put_byte} << {acc_cnt_q[2:0], 3'b000});
            out_cnt_d   = 4'(BYTES_PER_RESULT);
            out_last_d  = (cnt_q == 9'd1);
            out_end_d   = 1'b0;
            acc_d       = '0;
            acc_cnt_d   = 4'd0;
          end else begin
            acc_d     = acc_q | ({56'd0, put_byte} << {acc_cnt_q[2:0], 3'b000});
            acc_cnt_d = acc_cnt_q + 4'd1;
          end
          if (cnt_q == 9'd1) begin
            lit_d   = 1'b0;
            state_d = acc_full ? ST_WALK : ST_FLUSH;
          end else begin
            state_d = ST_COPY_RD;
          end
        end
      end

      // partial result closing the item's output
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bytes_d = acc_q;
          out_cnt_d   = acc_cnt_q;
          out_last_d  = 1'b1;
          out_end_d   = 1'b0;
          acc_d       = '0;
          acc_cnt_d   = 4'd0;
          state_d     = ST_WALK;
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bytes_d = '0;
          out_cnt_d   = 4'd0;
          out_last_d  = 1'b1;
          out_end_d   = 1'b1;
          finished_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // one flag bit per cycle until a byte is needed
      ST_WALK: begin
        if (reload_q != RL_NONE || !(phase_q == PH_FLAG || phase_q == PH_LEN_TREE ||
                                     phase_q == PH_OFF_TREE)) begin
          state_d = ST_IDLE;
        end else begin
          if (used_q == 5'd15) begin
            used_d   = 5'd0;
            reload_d = RL_LOW;
          end else begin
            used_d = used_q + 5'd1;
          end
          if (phase_q == PH_FLAG) begin
            node_d  = 6'd0;
            phase_d = cur_bit ? PH_LEN_TREE : PH_LITERAL;
          end else begin
            node_d = walk.node;
            if (walk.leaf) begin
              node_d = 6'd0;
              if (phase_q == PH_LEN_TREE) begin
                if (walk.value == ESC_VALUE) begin
                  phase_d = PH_ESCAPE;
                end else begin
                  pend_d  = {4'd0, walk.value};
                  oh_d    = 5'd0;
                  phase_d = (walk.value == 5'd2) ? PH_OFF_LOW : PH_OFF_TREE;
                end
              end else begin
                oh_d    = walk.value;
                phase_d = PH_OFF_LOW;
              end
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FLAG;
      reload_q    <= RL_LOW;
      flag_word_q <= 16'd0;
      used_q      <= 5'd0;
      node_q      <= 6'd0;
      pend_q      <= 9'd0;
      oh_q        <= 5'd0;
      wp_q        <= '0;
      written_q   <= 14'd0;
      finished_q  <= 1'b0;
      cnt_q       <= 9'd0;
      lit_q       <= 1'b0;
      acc_cnt_q   <= 4'd0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      reload_q    <= reload_d;
      flag_word_q <= flag_word_d;
      used_q      <= used_d;
      node_q      <= node_d;
      pend_q      <= pend_d;
      oh_q        <= oh_d;
      wp_q        <= wp_d;
      written_q   <= written_d;
      finished_q  <= finished_d;
      cnt_q       <= cnt_d;
      lit_q       <= lit_d;
      acc_cnt_q   <= acc_cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    off_q       <= off_d;
    lit_byte_q  <= lit_byte_d;
    src_ok_q    <= src_ok_d;
    out_bytes_q <= out_bytes_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
    out_end_q   <= out_end_d;
  end

  // an empty result is only ever the end report
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cnt_q == 4'd0) |-> out_end_q)
    else $error("empty result without end flag");

  // the end report always closes its run
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_last_q)
    else $error("end result not marked last");

  // once finished the sequencer stays idle
  a_finished_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> (state_q == ST_IDLE) && finished_q)
    else $error("activity after end of stream");

  // a new result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_bytes_q))
    else $error("stalled result overwritten");

endmodule

[tb/sv/lz_bitflag_decompressor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_bitflag_decompressor_test
// self-checking bench: a planned compressed stream goes in, and every packed
// output item is compared with a software decoder kept in step with the inputs
// ----------------------------------------------------------------------------
module lz_bitflag_decompressor_test;
  import lzbd_pkg::*;

  localparam int N_ITEMS    = 320;
  localparam int HIST_DEPTH = 8192;
  localparam int STALL_MAX  = 5000;  // cycles with no item moving on either side

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        fin;
  } chunk_t;

  // software decoder and store of the output items it predicts
  class lzbd_scoreboard;
    logic [15:0] fw;
    int          used;
    reload_e     rl;
    phase_e      ph;
    int          node;
    int          plen;
    int          ohi;
    logic [7:0]  hist[HIST_DEPTH];
    int          wpos;
    int          written;
    bit          fin;
    logic [63:0] acc_w;
    int          acc_n;
    chunk_t      step_q[$];
    chunk_t      want_q[$];
    int          errors;
    int          n_lit;
    int          n_copy;
    int          n_skip;

    function new();
      fw = '0;
      used = 0;
      rl = RL_LOW;
      ph = PH_FLAG;
      node = 0;
      plen = 0;
      ohi = 0;
      foreach (hist[i]) hist[i] = '0;
      wpos = 0;
      written = 0;
      fin = 0;
      errors = 0;
      n_lit = 0;
      n_copy = 0;
      n_skip = 0;
    endfunction

    function void close_chunk(logic [63:0] d, int c, bit e);
      step_q.push_back('{data: d, cnt: c[3:0], last: 1'b0, fin: e});
    endfunction

    function void put(logic [7:0] b);
      hist[wpos] = b;
      wpos = (wpos + 1) % HIST_DEPTH;
      if (written < int'(WRITTEN_CAP)) written++;
      acc_w |= 64'(b) << (8 * acc_n);
      acc_n++;
      if (acc_n == 8) begin
        close_chunk(acc_w, acc_n, 0);
        acc_w = '0;
        acc_n = 0;
      end
    endfunction

    function void copy_back(int offset, int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
        b = '0;
        // offset zero and sources before the first output byte read zero
        if (offset != 0 && offset <= written && offset < HIST_DEPTH)
          b = hist[(wpos + HIST_DEPTH - offset) % HIST_DEPTH];
        put(b);
      end
    endfunction

    function void walk();
      bit     fbit;
      int     nx;
      tnode_t t;
      while (rl == RL_NONE && (ph == PH_FLAG || ph == PH_LEN_TREE || ph == PH_OFF_TREE)) begin
        fbit = fw[used];
        used++;
        if (used == 16) begin
          used = 0;
          rl = RL_LOW;
        end
        if (ph == PH_FLAG) begin
          node = 0;
          ph = fbit ? PH_LEN_TREE : PH_LITERAL;
        end else if (ph == PH_LEN_TREE) begin
          t = LEN_TREE[node];
          nx = node + (fbit ? int'(t.r) : int'(t.l));
          if (nx >= int'(LEN_TREE_SIZE)) nx = 0;
          node = nx;
          t = LEN_TREE[nx];
          if (t.l == 0 && t.r == 0) begin
            node = 0;
            if (t.v == ESC_VALUE) begin
              ph = PH_ESCAPE;
            end else begin
              plen = t.v;
              ohi = 0;
              ph = (t.v == 2) ? PH_OFF_LOW : PH_OFF_TREE;
            end
          end
        end else begin
          t = OFF_TREE[node];
          nx = node + (fbit ? int'(t.r) : int'(t.l));
          if (nx >= int'(OFF_TREE_SIZE)) nx = 0;
          node = nx;
          t = OFF_TREE[nx];
          if (t.l == 0 && t.r == 0) begin
            node = 0;
            ohi = t.v;
            ph = PH_OFF_LOW;
          end
        end
      end
    endfunction

    // one accepted compressed byte
    function void note_input(logic [7:0] b);
      if (fin) return;
      step_q.delete();
      acc_w = '0;
      acc_n = 0;
      if (rl == RL_LOW) begin
        fw = {8'h00, b};
        rl = RL_HIGH;
      end else if (rl == RL_HIGH) begin
        fw[15:8] = b;
        rl = RL_NONE;
      end else begin
        case (ph)
          PH_LITERAL: begin
            put(b);
            n_lit++;
            ph = PH_FLAG;
          end
          PH_ESCAPE: begin
            if (b == SKIP_CODE) begin
              n_skip++;
              ph = PH_FLAG;
            end else if (b == END_CODE) begin
              fin = 1;
              ph = PH_FLAG;
              close_chunk('0, 0, 1);
            end else begin
              plen = int'(b) + int'(ESC_LEN);
              node = 0;
              ph = PH_OFF_TREE;
            end
          end
          PH_OFF_LOW: begin
            copy_back((ohi << 8) | int'(b), plen);
            n_copy++;
            ph = PH_FLAG;
          end
          default: ph = PH_FLAG;
        endcase
      end
      if (!fin) walk();
      if (acc_n != 0) close_chunk(acc_w, acc_n, 0);
      if (step_q.size() > 0) step_q[$].last = 1'b1;
      foreach (step_q[i]) want_q.push_back(step_q[i]);
    endfunction

    function void check(logic [63:0] d, logic [3:0] c, logic l, logic e);
      chunk_t w;
      if (want_q.size() == 0) begin
        $error("output item with nothing expected: out_bytes %h", d);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (d !== w.data) begin
        $error("out_bytes: expected %h, got %h", w.data, d);
        errors++;
      end
      if (c !== w.cnt) begin
        $error("byte_count: expected %0d, got %0d", w.cnt, c);
        errors++;
      end
      if (l !== w.last) begin
        $error("last_of_run: expected %b, got %b", w.last, l);
        errors++;
      end
      if (e !== w.fin) begin
        $error("stream_end: expected %b, got %b", w.fin, e);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lzbd_in_if  in_if ();
  lzbd_out_if out_if ();

  lz_bitflag_decompressor DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lzbd_scoreboard sb = new();

  // stream planner: control bits and the bytes that go with them
  bit          ctl_q[$];
  logic [7:0]  lit_q[$];
  logic [7:0]  esc_q[$];
  logic [7:0]  offlo_q[$];
  logic [15:0] len_bits[26];
  int          len_n[26];
  logic [15:0] off_bits[32];
  int          off_n[32];

  bit ending;   // steer toward the end code
  bit quiet;    // stretch with no idling on either side
  bit hold;     // long receiver hold-off
  int accepted;
  int results_seen;
  int dead_cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // prefix code of every leaf, from walking both trees top down
  function automatic void build_codes();
    logic [15:0] pb[63];
    int          pn[63];
    int          ch;
    pb[0] = '0;
    pn[0] = 0;
    for (int n = 0; n < int'(LEN_TREE_SIZE); n++) begin
      if (LEN_TREE[n].l == 0 && LEN_TREE[n].r == 0) begin
        len_bits[LEN_TREE[n].v] = pb[n];
        len_n[LEN_TREE[n].v] = pn[n];
      end else begin
        ch = n + LEN_TREE[n].l;
        pb[ch] = pb[n];
        pn[ch] = pn[n] + 1;
        ch = n + LEN_TREE[n].r;
        pb[ch] = pb[n] | (16'd1 << pn[n]);
        pn[ch] = pn[n] + 1;
      end
    end
    pb[0] = '0;
    pn[0] = 0;
    for (int n = 0; n < int'(OFF_TREE_SIZE); n++) begin
      if (OFF_TREE[n].l == 0 && OFF_TREE[n].r == 0) begin
        off_bits[OFF_TREE[n].v] = pb[n];
        off_n[OFF_TREE[n].v] = pn[n];
      end else begin
        ch = n + OFF_TREE[n].l;
        pb[ch] = pb[n];
        pn[ch] = pn[n] + 1;
        ch = n + OFF_TREE[n].r;
        pb[ch] = pb[n] | (16'd1 << pn[n]);
        pn[ch] = pn[n] + 1;
      end
    end
  endfunction

  function automatic void plan_literal(logic [7:0] v);
    ctl_q.push_back(1'b0);
    lit_q.push_back(v);
  endfunction

  // len 25 is the escape; esc is the byte that follows it
  function automatic void plan_match(int len, int hi, logic [7:0] esc, logic [7:0] lo);
    ctl_q.push_back(1'b1);
    for (int i = 0; i < len_n[len]; i++) ctl_q.push_back(len_bits[len][i]);
    if (len == 25) begin
      esc_q.push_back(esc);
      if (esc == SKIP_CODE || esc == END_CODE) return;
    end
    if (len != 2)
      for (int i = 0; i < off_n[hi]; i++) ctl_q.push_back(off_bits[hi][i]);
    offlo_q.push_back(lo);
  endfunction

  function automatic void plan_token();
    int         len;
    int         hi;
    int         r;
    logic [7:0] esc;
    logic [7:0] lo;
    if (ending) begin
      plan_match(25, 0, END_CODE, 8'h00);
      return;
    end
    if ($urandom_range(99) < 40) begin
      plan_literal(8'($urandom_range(255)));
      return;
    end
    len = ($urandom_range(9) == 0) ? 25 : $urandom_range(24, 2);
    r = $urandom_range(99);
    hi = (r < 60) ? 0 : (r < 85) ? $urandom_range(3, 1) : $urandom_range(31);
    r = $urandom_range(99);
    if (r < 15) esc = SKIP_CODE;
    else if (r < 95) esc = 8'($urandom_range(15));
    else esc = 8'($urandom_range(253));
    lo = ($urandom_range(1) == 0) ? 8'($urandom_range(16, 1)) : 8'($urandom_range(255));
    plan_match(len, hi, esc, lo);
  endfunction

  // byte that the decoder wants next, chosen from its current phase
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    if (sb.fin) return 8'($urandom_range(255));
    if (sb.rl != RL_NONE) begin
      // occasional raw flag byte as noise
      if (!ending && $urandom_range(9) == 0) return 8'($urandom_range(255));
      while (ctl_q.size() < 8) plan_token();
      for (int i = 0; i < 8; i++) v[i] = ctl_q.pop_front();
      return v;
    end
    case (sb.ph)
      PH_LITERAL: return (lit_q.size() > 0) ? lit_q.pop_front() : 8'($urandom_range(255));
      PH_ESCAPE: begin
        v = (esc_q.size() > 0) ? esc_q.pop_front() : 8'($urandom_range(15));
        if (ending) return END_CODE;
        return (v == END_CODE) ? SKIP_CODE : v;
      end
      PH_OFF_LOW: return (offlo_q.size() > 0) ? offlo_q.pop_front() : 8'($urandom_range(255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one item, starting at a falling edge; returns at the falling edge
  // after acceptance with valid still high
  task automatic push_byte(logic [7:0] b);
    while (!quiet && $urandom_range(99) < 28) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.in_byte = b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(b);
    accepted++;
    @(negedge clk_i);
  endtask

  // receiver side: random ready, or held low during the pressure window
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold) out_if.ready = 1'b0;
      else out_if.ready = quiet || ($urandom_range(99) >= 28);
    end
  end

  // long hold-off while the sender keeps offering, so the block backs up
  initial begin
    hold = 1'b0;
    wait (accepted >= 60);
    hold = 1'b1;
    repeat (400) @(posedge clk_i);
    hold = 1'b0;
  end

  // no idling while items 150..229 go in
  always @(posedge clk_i) quiet <= (accepted >= 150 && accepted < 230);

  // output compare and the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check(out_if.out_bytes, out_if.byte_count, out_if.last_of_run, out_if.stream_end);
        results_seen++;
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) dead_cycles = 0;
      else dead_cycles++;
      if (dead_cycles >= STALL_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    ending = 0;
    accepted = 0;
    results_seen = 0;
    dead_cycles = 0;
    build_codes();

    // directed opening: extreme literals, offset zero, source before output
    // start, skip code, self-overlapping copy, longest escaped length with the
    // largest offset
    plan_literal(8'h00);
    plan_literal(8'hFF);
    plan_literal(8'h5A);
    plan_match(2, 0, 8'h00, 8'h00);
    plan_match(3, 0, 8'h00, 8'hC8);
    plan_match(25, 0, SKIP_CODE, 8'h00);
    plan_match(24, 0, 8'h00, 8'h01);
    plan_match(25, 31, 8'hFD, 8'hFF);
    plan_match(5, 0, 8'h00, 8'h03);
    plan_literal(8'h81);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    while (accepted < N_ITEMS) push_byte(pick_byte());
    // steer to the end code, then a few items the block should drop
    ending = 1;
    ctl_q.delete();
    while (!sb.fin) push_byte(pick_byte());
    repeat (4) push_byte(8'($urandom_range(255)));
    in_if.valid = 1'b0;

    while (sb.want_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("run: %0d items in, %0d items out", accepted, results_seen);
    $display("decoded %0d literals, %0d copies, %0d skips, end code seen",
             sb.n_lit, sb.n_copy, sb.n_skip);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lzbd_pkg.sv
src/lzbd_if.sv
src/lzbd_code_walker.sv
src/lzbd_history.sv
src/lz_bitflag_decompressor.sv
tb/sv/lz_bitflag_decompressor_test.sv
